// ----- rtl/core/adet_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Envelope tracker package
// Shared widths, reset values and codes of the attack/decay envelope tracker.
// ----------------------------------------------------------------------------
package adet_pkg;

    localparam int SAMPLE_BITS_DEF = 24;
    localparam int FRAC_BITS_DEF   = 8;
    localparam int LEVEL_BITS      = 32;
    localparam int SPEED_BITS      = 8;
    localparam int CFG_DATA_BITS   = 32;
    localparam int CFG_INDEX_BITS  = 3;

    localparam logic [SPEED_BITS-1:0] ATTACK_RESET = 8'd8;
    localparam logic [SPEED_BITS-1:0] DECAY_RESET  = 8'd32;
    localparam logic [SPEED_BITS-1:0] MIN_RESET    = 8'd2;
    localparam logic [SPEED_BITS-1:0] MAX_RESET    = 8'd128;
    localparam logic signed [LEVEL_BITS-1:0] PRESET_RESET = '0;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_ATTACK       = 3'd0,
        CFG_DECAY        = 3'd1,
        CFG_MODE         = 3'd2,
        CFG_MIN_SPEED    = 3'd3,
        CFG_MAX_SPEED    = 3'd4,
        CFG_PRESET_UPPER = 3'd5,
        CFG_PRESET_LOWER = 3'd6
    } cfg_index_t;

    typedef enum logic [1:0] {
        MODE_UPPER = 2'd0,
        MODE_LOWER = 2'd1,
        MODE_BOTH  = 2'd2,
        MODE_BAD   = 2'd3
    } mode_t;

    localparam logic [1:0] SEL_UPPER = 2'd0;
    localparam logic [1:0] SEL_LOWER = 2'd1;
    localparam logic [1:0] SEL_MODE  = 2'd2;

    typedef enum logic [2:0] {
        STAT_OK         = 3'd0,
        STAT_BAD_ATTACK = 3'd1,
        STAT_BAD_DECAY  = 3'd2,
        STAT_BAD_MODE   = 3'd3,
        STAT_NO_LEVEL   = 3'd4
    } status_t;

endpackage : adet_pkg
`default_nettype wire

// ----- rtl/core/adet_in_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sample channel
// Valid/ready channel that carries one sensor sample request.
// ----------------------------------------------------------------------------
interface adet_in_if
    import adet_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic [1:0]                    return_select;

    modport source (output valid, output sample, output return_select, input ready);
    modport sink   (input valid, input sample, input return_select, output ready);
endinterface : adet_in_if
`default_nettype wire

// ----- rtl/core/adet_out_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel that carries the envelope levels and status of one step.
// ----------------------------------------------------------------------------
interface adet_out_if
    import adet_pkg::*;
;
    logic                         valid;
    logic                         ready;
    logic signed [LEVEL_BITS-1:0] upper_level;
    logic signed [LEVEL_BITS-1:0] lower_level;
    logic signed [LEVEL_BITS-1:0] selected_level;
    status_t                      status;

    modport source (output valid, output upper_level, output lower_level,
                    output selected_level, output status, input ready);
    modport sink   (input valid, input upper_level, input lower_level,
                    input selected_level, input status, output ready);
endinterface : adet_out_if
`default_nettype wire

// ----- rtl/core/adet_divider.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Radix-2 divider
// Restoring unsigned division of a wide magnitude by a speed, one bit a cycle.
// ----------------------------------------------------------------------------
module adet_divider
    import adet_pkg::*;
#(
    parameter int DIVIDEND_BITS = 33
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     start,
    input  wire logic [DIVIDEND_BITS-1:0] dividend,
    input  wire logic [SPEED_BITS-1:0]    divisor,
    output logic                          done,
    output logic [DIVIDEND_BITS-1:0]      quotient
);
    localparam int CNT_BITS = $clog2(DIVIDEND_BITS);

    logic                     busy_reg,    busy_next;
    logic                     done_reg,    done_next;
    logic [CNT_BITS-1:0]      count_reg,   count_next;
    logic [SPEED_BITS-1:0]    divisor_reg, divisor_next;
    logic [SPEED_BITS-1:0]    rem_reg,     rem_next;
    logic [DIVIDEND_BITS-1:0] quo_reg,     quo_next;
    logic [SPEED_BITS:0]      trial;

    always_comb
    begin
        busy_next    = busy_reg;
        done_next    = 1'b0;
        count_next   = count_reg;
        divisor_next = divisor_reg;
        rem_next     = rem_reg;
        quo_next     = quo_reg;
        trial        = {rem_reg, quo_reg[DIVIDEND_BITS-1]};
        if (start)
        begin
            busy_next    = 1'b1;
            count_next   = '0;
            divisor_next = divisor;
            rem_next     = '0;
            quo_next     = dividend;
        end
        else if (busy_reg)
        begin
            // Shift one dividend bit into the remainder and subtract if it fits.
            if (trial >= {1'b0, divisor_reg})
            begin
                rem_next = SPEED_BITS'(trial - {1'b0, divisor_reg});
                quo_next = {quo_reg[DIVIDEND_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[SPEED_BITS-1:0];
                quo_next = {quo_reg[DIVIDEND_BITS-2:0], 1'b0};
            end
            count_next = count_reg + CNT_BITS'(1);
            if (count_reg == CNT_BITS'(DIVIDEND_BITS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        divisor_reg <= divisor_next;
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule : adet_divider
`default_nettype wire

// ----- rtl/core/attack_decay_envelope_tracker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Attack/decay envelope tracker
// Follows the upper and lower envelopes of a touch-sensor sample stream.
// ----------------------------------------------------------------------------
// Each request on the samples channel carries one signed sample and a select
// code. The sample is scaled to the level format and every tracked envelope
// moves toward it by the difference divided by the attack or decay speed.
// One request on the results channel answers each sample request.
// The one shared radix-2 divider takes one quotient bit a cycle over a
// difference of DW = max(SAMPLE_BITS + FRAC_BITS, 32) + 1 bits. A sample that
// updates both envelopes runs the upper and then the lower division on it;
// one rejected by its status goes to the result without any division.
// The samples channel is ready only while no sample is being worked on.
// The result is held in an output register, so the next sample is accepted
// while the receiver still stalls on the previous result; a finished result
// waits until that register is free.
// Reset restores the register defaults and loads both envelopes with the
// preset levels. Configuration writes are taken at any cycle, but are meant
// to be made while the block is idle; writing a preset also loads its envelope.
// ----------------------------------------------------------------------------
module attack_decay_envelope_tracker
    import adet_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_we,
    input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0]  cfg_wdata,
    adet_in_if.sink                        samples,
    adet_out_if.source                     results
);
    // Width of the scaled sample and of the difference to a level.
    localparam int TARGET_BITS = SAMPLE_BITS + FRAC_BITS;
    localparam int DW = ((TARGET_BITS > LEVEL_BITS) ? TARGET_BITS : LEVEL_BITS) + 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_UP_START,
        S_UP_WAIT,
        S_LO_START,
        S_LO_WAIT,
        S_FINISH
    } state_t;

    state_t                        state_reg,  state_next;
    logic [SPEED_BITS-1:0]         attack_reg, attack_next;
    logic [SPEED_BITS-1:0]         decay_reg,  decay_next;
    mode_t                         mode_reg,   mode_next;
    logic [SPEED_BITS-1:0]         min_reg,    min_next;
    logic [SPEED_BITS-1:0]         max_reg,    max_next;
    logic signed [LEVEL_BITS-1:0]  upper_reg,  upper_next;
    logic signed [LEVEL_BITS-1:0]  lower_reg,  lower_next;
    logic signed [SAMPLE_BITS-1:0] sample_reg, sample_next;
    logic [1:0]                    sel_reg,    sel_next;
    status_t                       status_reg, status_next;
    logic                          ovalid_reg, ovalid_next;
    logic signed [LEVEL_BITS-1:0]  oupper_reg, oupper_next;
    logic signed [LEVEL_BITS-1:0]  olower_reg, olower_next;
    logic signed [LEVEL_BITS-1:0]  osel_reg,   osel_next;
    status_t                       ostat_reg,  ostat_next;

    logic                          accept;
    logic                          lower_phase;
    logic signed [LEVEL_BITS-1:0]  env_sel;
    logic signed [DW-1:0]          target;
    logic signed [DW-1:0]          diff;
    logic                          diff_neg;
    logic [DW-1:0]                 diff_mag;
    logic                          outside;
    logic signed [DW:0]            q_signed;
    logic signed [DW:0]            sum;
    logic signed [LEVEL_BITS-1:0]  new_level;
    logic                          div_start;
    logic [SPEED_BITS-1:0]         div_divisor;
    logic                          div_done;
    logic [DW-1:0]                 div_quotient;
    logic [1:0]                    eff_sel;

    // A speed of zero is never accepted, whatever the lower bound says.
    function automatic logic speed_ok(input logic [SPEED_BITS-1:0] s,
                                      input logic [SPEED_BITS-1:0] lo,
                                      input logic [SPEED_BITS-1:0] hi);
        speed_ok = (s != '0) && (s >= lo) && (s <= hi);
    endfunction

    assign accept = samples.valid && samples.ready;

    // One subtractor serves both envelopes; the phase picks the level.
    assign lower_phase = (state_reg == S_LO_START) || (state_reg == S_LO_WAIT);
    assign env_sel     = lower_phase ? lower_reg : upper_reg;
    assign target      = DW'(sample_reg) <<< FRAC_BITS;
    assign diff        = target - DW'(env_sel);
    assign diff_neg    = diff[DW-1];
    assign diff_mag    = diff_neg ? DW'(-diff) : DW'(diff);

    // The sample is outside when it lies above the upper or below the lower level.
    assign outside     = lower_phase ? diff_neg : (!diff_neg && (diff != '0));
    assign div_divisor = outside ? attack_reg : decay_reg;
    assign div_start   = (state_reg == S_UP_START) || (state_reg == S_LO_START);

    // The quotient takes the sign of the difference, so it truncates toward zero.
    assign q_signed = diff_neg ? -$signed({1'b0, div_quotient})
                               :  $signed({1'b0, div_quotient});
    assign sum      = (DW + 1)'(env_sel) + q_signed;

    // Saturate when the bits above the level's sign do not all agree with it.
    always_comb
    begin
        if ((&sum[DW:LEVEL_BITS-1]) || !(|sum[DW:LEVEL_BITS-1]))
        begin
            new_level = sum[LEVEL_BITS-1:0];
        end
        else if (sum[DW])
        begin
            new_level = {1'b1, {(LEVEL_BITS-1){1'b0}}};
        end
        else
        begin
            new_level = {1'b0, {(LEVEL_BITS-1){1'b1}}};
        end
    end

    adet_divider #(
        .DIVIDEND_BITS(DW)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (diff_mag),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    always_comb
    begin
        state_next  = state_reg;
        attack_next = attack_reg;
        decay_next  = decay_reg;
        mode_next   = mode_reg;
        min_next    = min_reg;
        max_next    = max_reg;
        upper_next  = upper_reg;
        lower_next  = lower_reg;
        sample_next = sample_reg;
        sel_next    = sel_reg;
        status_next = status_reg;
        ovalid_next = ovalid_reg;
        oupper_next = oupper_reg;
        olower_next = olower_reg;
        osel_next   = osel_reg;
        ostat_next  = ostat_reg;
        eff_sel     = (sel_reg == SEL_MODE) ? 2'(mode_reg) : sel_reg;

        if (results.valid && results.ready)
        begin
            ovalid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    sample_next = samples.sample;
                    sel_next    = samples.return_select;
                    // Status checks in priority order: attack, decay, mode.
                    if (!speed_ok(attack_reg, min_reg, max_reg))
                    begin
                        status_next = STAT_BAD_ATTACK;
                        state_next  = S_FINISH;
                    end
                    else if (!speed_ok(decay_reg, min_reg, max_reg))
                    begin
                        status_next = STAT_BAD_DECAY;
                        state_next  = S_FINISH;
                    end
                    else if (mode_reg == MODE_BAD)
                    begin
                        status_next = STAT_BAD_MODE;
                        state_next  = S_FINISH;
                    end
                    else
                    begin
                        status_next = STAT_OK;
                        state_next  = (mode_reg == MODE_LOWER) ? S_LO_START : S_UP_START;
                    end
                end
            end
            S_UP_START:
            begin
                state_next = S_UP_WAIT;
            end
            S_UP_WAIT:
            begin
                if (div_done)
                begin
                    upper_next = new_level;
                    state_next = (mode_reg == MODE_BOTH) ? S_LO_START : S_FINISH;
                end
            end
            S_LO_START:
            begin
                state_next = S_LO_WAIT;
            end
            S_LO_WAIT:
            begin
                if (div_done)
                begin
                    lower_next = new_level;
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                // The result waits here until the output register is free.
                if (!results.valid || results.ready)
                begin
                    ovalid_next = 1'b1;
                    oupper_next = upper_reg;
                    olower_next = lower_reg;
                    osel_next   = '0;
                    ostat_next  = status_reg;
                    if (status_reg == STAT_OK)
                    begin
                        if (eff_sel == SEL_UPPER)
                        begin
                            osel_next = upper_reg;
                        end
                        else if (eff_sel == SEL_LOWER)
                        begin
                            osel_next = lower_reg;
                        end
                        else
                        begin
                            ostat_next = STAT_NO_LEVEL;
                        end
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_ATTACK:       attack_next = cfg_wdata[SPEED_BITS-1:0];
                CFG_DECAY:        decay_next  = cfg_wdata[SPEED_BITS-1:0];
                CFG_MODE:         mode_next   = mode_t'(cfg_wdata[1:0]);
                CFG_MIN_SPEED:    min_next    = cfg_wdata[SPEED_BITS-1:0];
                CFG_MAX_SPEED:    max_next    = cfg_wdata[SPEED_BITS-1:0];
                CFG_PRESET_UPPER: upper_next  = $signed(cfg_wdata[LEVEL_BITS-1:0]);
                CFG_PRESET_LOWER: lower_next  = $signed(cfg_wdata[LEVEL_BITS-1:0]);
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            attack_reg <= ATTACK_RESET;
            decay_reg  <= DECAY_RESET;
            mode_reg   <= MODE_UPPER;
            min_reg    <= MIN_RESET;
            max_reg    <= MAX_RESET;
            upper_reg  <= PRESET_RESET;
            lower_reg  <= PRESET_RESET;
            status_reg <= STAT_OK;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            attack_reg <= attack_next;
            decay_reg  <= decay_next;
            mode_reg   <= mode_next;
            min_reg    <= min_next;
            max_reg    <= max_next;
            upper_reg  <= upper_next;
            lower_reg  <= lower_next;
            status_reg <= status_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sample_reg <= sample_next;
        sel_reg    <= sel_next;
        oupper_reg <= oupper_next;
        olower_reg <= olower_next;
        osel_reg   <= osel_next;
        ostat_reg  <= ostat_next;
    end

    assign samples.ready          = (state_reg == S_IDLE);
    assign results.valid          = ovalid_reg;
    assign results.upper_level    = oupper_reg;
    assign results.lower_level    = olower_reg;
    assign results.selected_level = osel_reg;
    assign results.status         = ostat_reg;

`ifndef SYNTHESIS
    // The divider only finishes while the sequencer waits for it.
    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_UP_WAIT || state_reg == S_LO_WAIT))
        else $error("divider finished outside a wait state");

    // A rejected sample goes straight to the result without any division.
    a_reject_skips: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && status_next != STAT_OK) |=> (state_reg == S_FINISH))
        else $error("rejected sample did not go to the result stage");

    // Any error status comes with a zero selected level.
    a_err_zero_sel: assert property (@(posedge clk) disable iff (!rst_n)
        (results.valid && results.status != STAT_OK) |-> (results.selected_level == '0))
        else $error("selected level not zero with an error status");

    // The envelopes only change through a division result or a preset write.
    a_env_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!cfg_we && !div_done) |=> $stable(upper_reg) && $stable(lower_reg))
        else $error("envelope changed without an update");
`endif

endmodule : attack_decay_envelope_tracker
`default_nettype wire
